>>> design/rtc_pkg.sv
// shared types, register indexes and bcd helpers for the bcd real-time clock
// used by rtc_tick and bcd_rtc_with_alarms_i2c_regs_unit; no dependencies
package rtc_pkg;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] wdata;
  } rtc_in_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       int_n;
  } rtc_out_t;

  typedef logic [15:0][7:0] regfile_t;

  // register map
  localparam logic [3:0] R_SEC   = 4'd0;
  localparam logic [3:0] R_MIN   = 4'd1;
  localparam logic [3:0] R_HOUR  = 4'd2;
  localparam logic [3:0] R_WDAY  = 4'd3;
  localparam logic [3:0] R_DAY   = 4'd4;
  localparam logic [3:0] R_MON   = 4'd5;
  localparam logic [3:0] R_YEAR  = 4'd6;
  localparam logic [3:0] R_WMIN  = 4'd8;
  localparam logic [3:0] R_WHOUR = 4'd9;
  localparam logic [3:0] R_WWEEK = 4'd10;
  localparam logic [3:0] R_DMIN  = 4'd11;
  localparam logic [3:0] R_DHOUR = 4'd12;
  localparam logic [3:0] R_CTL1  = 4'd14;
  localparam logic [3:0] R_CTL2  = 4'd15;

  localparam logic [7:0] DAY_RST  = 8'h01;
  localparam logic [7:0] MON_RST  = 8'h01;
  localparam logic [7:0] CTL2_RST = 8'h30;

  // whole register file after reset: ctrl2 in byte 15, month in 5, day in 4
  localparam regfile_t REGS_RST = {CTL2_RST, 72'h0, MON_RST, DAY_RST, 32'h0};

  // tick results passed back to the register file
  typedef struct packed {
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hour;
    logic [7:0] wday;
    logic [7:0] day;
    logic [7:0] mon;
    logic [7:0] year;
    logic [7:0] ctl2;
    logic       fired;
  } tick_res_t;

  // tens*10 + units, digits above nine taken as they are
  function automatic logic [7:0] bcd_val(input logic [7:0] b);
    logic [7:0] hi;
    hi = {4'd0, b[7:4]};
    return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
  endfunction

  // (v/10)<<4 | v%10 truncated to a byte; v/10 via reciprocal 205/2048
  function automatic logic [7:0] val_bcd(input logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  r;
    prod = {8'd0, v} * 16'd205;
    q    = prod[15:11];
    r    = v - ({3'd0, q} * 8'd10);
    return {q[3:0], r[3:0]};
  endfunction

  // month length; months outside 1..12 count as 30 days
  function automatic logic [7:0] month_days(input logic [7:0] mo, input logic [7:0] yr);
    logic leap;
    // 2000+yr: divisible by 4 unless it is 2100
    leap = (yr[1:0] == 2'd0) && (yr != 8'd100);
    case (mo)
      8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: return 8'd31;
      8'd4, 8'd6, 8'd9, 8'd11:                    return 8'd30;
      8'd2:    return leap ? 8'd29 : 8'd28;
      default: return 8'd30;
    endcase
  endfunction

endpackage

>>> design/rtc_tick.sv
// one-second calendar advance and alarm flag evaluation, purely combinational
// depends on rtc_pkg
module rtc_tick (
  input  rtc_pkg::regfile_t  regs,
  output rtc_pkg::tick_res_t res
);

  logic [7:0] s, m, h, wd, dd, mo, yr;
  logic [7:0] s_inc, m_inc, h_inc, wd_inc, dd_inc, mo_inc, yr_inc;
  logic       c_s, c_m, c_h, c_d, c_mo;
  logic [7:0] s_n, m_n, h_n, wd_n, dd_n, mo_n, yr_n;
  logic [7:0] ctl1;
  logic       wk_hit, dy_hit;

  always_comb begin
    s  = rtc_pkg::bcd_val(regs[rtc_pkg::R_SEC]  & 8'h7F);
    m  = rtc_pkg::bcd_val(regs[rtc_pkg::R_MIN]  & 8'h7F);
    h  = rtc_pkg::bcd_val(regs[rtc_pkg::R_HOUR] & 8'h3F);
    wd = rtc_pkg::bcd_val(regs[rtc_pkg::R_WDAY] & 8'h07);
    dd = rtc_pkg::bcd_val(regs[rtc_pkg::R_DAY]  & 8'h3F);
    mo = rtc_pkg::bcd_val(regs[rtc_pkg::R_MON]  & 8'h1F);
    yr = rtc_pkg::bcd_val(regs[rtc_pkg::R_YEAR]);

    s_inc  = s + 8'd1;
    m_inc  = m + 8'd1;
    h_inc  = h + 8'd1;
    wd_inc = wd + 8'd1;
    dd_inc = dd + 8'd1;
    mo_inc = mo + 8'd1;
    yr_inc = yr + 8'd1;

    // carry ripple
    c_s  = s_inc >= 8'd60;
    c_m  = c_s && (m_inc >= 8'd60);
    c_h  = c_m && (h_inc >= 8'd24);
    c_d  = c_h && (dd_inc > rtc_pkg::month_days(mo, yr));
    c_mo = c_d && (mo_inc > 8'd12);

    s_n  = c_s ? 8'd0 : s_inc;
    m_n  = c_s ? (c_m ? 8'd0 : m_inc) : m;
    h_n  = c_m ? (c_h ? 8'd0 : h_inc) : h;
    wd_n = c_h ? ((wd_inc >= 8'd7) ? wd_inc - 8'd7 : wd_inc) : wd;
    dd_n = c_h ? (c_d ? 8'd1 : dd_inc) : dd;
    mo_n = c_d ? (c_mo ? 8'd1 : mo_inc) : mo;
    yr_n = c_mo ? ((yr_inc > 8'd99) ? 8'd0 : yr_inc) : yr;

    res.sec  = rtc_pkg::val_bcd(s_n);
    res.min  = rtc_pkg::val_bcd(m_n);
    res.hour = rtc_pkg::val_bcd(h_n);
    res.wday = rtc_pkg::val_bcd(wd_n);
    res.day  = rtc_pkg::val_bcd(dd_n);
    res.mon  = rtc_pkg::val_bcd(mo_n);
    res.year = rtc_pkg::val_bcd(yr_n);

    ctl1 = regs[rtc_pkg::R_CTL1];
    // new weekday byte is below ten, so its low three bits pick the mask bit
    wk_hit = ctl1[7] && (res.min == regs[rtc_pkg::R_WMIN]) &&
             (res.hour == regs[rtc_pkg::R_WHOUR]) &&
             regs[rtc_pkg::R_WWEEK][res.wday[2:0]];
    dy_hit = ctl1[6] && (res.min == regs[rtc_pkg::R_DMIN]) &&
             (res.hour == regs[rtc_pkg::R_DHOUR]);

    res.ctl2 = regs[rtc_pkg::R_CTL2] |
               {5'd0, (ctl1[2:0] != 3'd0), wk_hit, dy_hit};
    res.fired = wk_hit || dy_hit;
  end

endmodule

>>> design/bcd_rtc_with_alarms_i2c_regs_unit.sv
// top level of the bcd real-time clock: input register, register file,
// bus pointer logic and result register; depends on rtc_pkg and rtc_tick
//
// requests pass the input register, then the result register
// one request per cycle unless stalled; stall goes back through one stage
// reset (rst_n low, synchronous): registers zero except day, month = 1 and
//   ctrl2 = 0x30, pointer 0, next write sets the pointer, interrupt flag cleared
module bcd_rtc_with_alarms_i2c_regs_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rtc_pkg::rtc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rtc_pkg::rtc_out_t out_data
);

  // input register stage
  logic             in_valid_r;
  rtc_pkg::rtc_in_t in_data_r;

  // result register stage
  logic              out_valid_r;
  rtc_pkg::rtc_out_t out_data_r;

  // architectural state
  rtc_pkg::regfile_t regs_r, regs_nxt;
  logic [3:0]        ptr_r, ptr_nxt;
  logic              phase_r, phase_nxt;
  logic              irq_r, irq_nxt;

  logic               out_load;   // result register free this cycle
  logic               go;         // held request is processed now
  logic [7:0]         rd_byte;
  rtc_pkg::tick_res_t tick;

  assign out_load = !out_valid_r || !out_stall;
  assign go       = in_valid_r && out_load;
  // input stage holds while its request cannot move on
  assign in_stall = in_valid_r && !out_load;

  rtc_tick u_tick (
    .regs (regs_r),
    .res  (tick)
  );

  always_comb begin
    regs_nxt  = regs_r;
    ptr_nxt   = ptr_r;
    phase_nxt = phase_r;
    irq_nxt   = irq_r;
    rd_byte   = 8'd0;
    if (go) begin
      case (in_data_r.mode)
        rtc_pkg::MODE_TICK: begin
          regs_nxt[rtc_pkg::R_SEC]  = tick.sec;
          regs_nxt[rtc_pkg::R_MIN]  = tick.min;
          regs_nxt[rtc_pkg::R_HOUR] = tick.hour;
          regs_nxt[rtc_pkg::R_WDAY] = tick.wday;
          regs_nxt[rtc_pkg::R_DAY]  = tick.day;
          regs_nxt[rtc_pkg::R_MON]  = tick.mon;
          regs_nxt[rtc_pkg::R_YEAR] = tick.year;
          regs_nxt[rtc_pkg::R_CTL2] = tick.ctl2;
          // sticky until reset
          irq_nxt = irq_r || tick.fired;
        end
        rtc_pkg::MODE_START: begin
          phase_nxt = 1'b0;
        end
        rtc_pkg::MODE_WRITE: begin
          if (!phase_r) begin
            // first byte after a start loads the pointer from its upper nibble
            ptr_nxt   = in_data_r.wdata[7:4];
            phase_nxt = 1'b1;
          end else begin
            regs_nxt[ptr_r] = in_data_r.wdata;
            ptr_nxt         = ptr_r + 4'd1;
          end
        end
        rtc_pkg::MODE_READ: begin
          rd_byte = regs_r[ptr_r];
          ptr_nxt = ptr_r + 4'd1;
        end
        default: begin
          rd_byte = 8'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      regs_r      <= rtc_pkg::REGS_RST;
      ptr_r       <= 4'd0;
      phase_r     <= 1'b0;
      irq_r       <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (out_load) begin
        out_valid_r <= in_valid_r;
      end
      regs_r  <= regs_nxt;
      ptr_r   <= ptr_nxt;
      phase_r <= phase_nxt;
      irq_r   <= irq_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
    if (go) begin
      // read byte, then the active-low interrupt level
      out_data_r <= {rd_byte, !irq_nxt};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
